### sv/kic_pkg.sv
// kic_pkg: shared widths, stage state types and digit-step functions
// for the kerr isco radius pipeline; no dependencies
package kic_pkg;

    localparam int WF          = 28;
    localparam int SPIN_W      = 16;
    localparam int OUT_W       = 20;
    localparam int CBRT_STAGES = 22;
    localparam int SQRT_STAGES = 32;
    localparam int CBRT_LANES  = 3;
    localparam int CBRT_IN_W   = 29;
    localparam int CBRT_OUT_W  = 22;
    localparam int SQRT_OUT_W  = 32;

    // partial state of the restoring cube root
    typedef struct packed {
        logic [23:0] y;
        logic [49:0] y2;
        logic [49:0] rem;
    } cbrt_st_t;

    // partial state of the restoring square root
    typedef struct packed {
        logic [31:0] root;
        logic [35:0] rem;
    } sqrt_st_t;

    // one 3-bit digit of the cube root, y squared kept alongside
    function automatic cbrt_st_t cbrt_step(cbrt_st_t s, logic [2:0] d);
        logic [23:0] ys;
        logic [49:0] y2s;
        logic [49:0] b;
        logic [49:0] rs;
        cbrt_st_t    o;
        ys  = s.y << 1;
        y2s = s.y2 << 2;
        b   = y2s + (y2s << 1) + {26'd0, ys} + {25'd0, ys, 1'b0} + 50'd1;
        rs  = {s.rem[46:0], d};
        if (rs >= b)
        begin
            o.rem = rs - b;
            o.y   = ys + 24'd1;
            o.y2  = y2s + {25'd0, ys, 1'b0} + 50'd1;
        end
        else
        begin
            o.rem = rs;
            o.y   = ys;
            o.y2  = y2s;
        end
        return o;
    endfunction

    // one 2-bit digit of the square root
    function automatic sqrt_st_t sqrt_step(sqrt_st_t s, logic [1:0] d);
        logic [35:0] rs;
        logic [35:0] trial;
        sqrt_st_t    o;
        rs    = {s.rem[33:0], d};
        trial = {2'b00, s.root, 2'b01};
        if (rs >= trial)
        begin
            o.rem  = rs - trial;
            o.root = {s.root[30:0], 1'b1};
        end
        else
        begin
            o.rem  = rs;
            o.root = {s.root[30:0], 1'b0};
        end
        return o;
    endfunction

endpackage

### sv/kic_cbrt_pipe.sv
// kic_cbrt_pipe: three-lane pipelined cube root, one digit per stage
// depends on kic_pkg
module kic_cbrt_pipe
    import kic_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [CBRT_IN_W-1:0]  in_x [CBRT_LANES],
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_vld,
    output logic [CBRT_OUT_W-1:0] out_root [CBRT_LANES],
    output logic [SIDE_W-1:0]     out_side
);

    cbrt_st_t             st_reg   [CBRT_STAGES][CBRT_LANES];
    logic [CBRT_IN_W-1:0] x_reg    [CBRT_STAGES][CBRT_LANES];
    logic [SIDE_W-1:0]    side_reg [CBRT_STAGES];
    logic [CBRT_STAGES-1:0] vld_reg;

    genvar g, l;
    generate
        for (g = 0; g < CBRT_STAGES; g++)
        begin : g_stage
            logic                 vld_prev;
            logic [SIDE_W-1:0]    side_prev;
            cbrt_st_t             st_prev [CBRT_LANES];
            logic [CBRT_IN_W-1:0] x_prev  [CBRT_LANES];

            // previous stage or pipe input
            if (g == 0)
            begin : g_first
                assign vld_prev  = in_vld;
                assign side_prev = in_side;
                for (l = 0; l < CBRT_LANES; l++)
                begin : g_lane
                    assign st_prev[l] = '0;
                    assign x_prev[l]  = in_x[l];
                end
            end
            else
            begin : g_next
                assign vld_prev  = vld_reg[g-1];
                assign side_prev = side_reg[g-1];
                for (l = 0; l < CBRT_LANES; l++)
                begin : g_lane
                    assign st_prev[l] = st_reg[g-1][l];
                    assign x_prev[l]  = x_reg[g-1][l];
                end
            end

            // valid bit
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (en)
                    vld_reg[g] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                    side_reg[g] <= side_prev;
            end

            // digit step per lane, operand is x shifted left by 35
            for (l = 0; l < CBRT_LANES; l++)
            begin : g_step
                logic [65:0] xw;
                cbrt_st_t    st_next;
                assign xw      = {2'b00, x_prev[l], 35'd0};
                assign st_next = cbrt_step(st_prev[l], xw[65-3*g -: 3]);
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        st_reg[g][l] <= st_next;
                        x_reg[g][l]  <= x_prev[l];
                    end
                end
            end
        end

        for (l = 0; l < CBRT_LANES; l++)
        begin : g_out
            assign out_root[l] = st_reg[CBRT_STAGES-1][l].y[CBRT_OUT_W-1:0];
        end
    endgenerate

    assign out_vld  = vld_reg[CBRT_STAGES-1];
    assign out_side = side_reg[CBRT_STAGES-1];

endmodule

### sv/kic_sqrt_pipe.sv
// kic_sqrt_pipe: pipelined integer square root of a 64-bit operand,
// one result bit per stage; depends on kic_pkg
module kic_sqrt_pipe
    import kic_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_vld,
    input  logic [63:0]           in_x,
    input  logic [SIDE_W-1:0]     in_side,
    output logic                  out_vld,
    output logic [SQRT_OUT_W-1:0] out_root,
    output logic [SIDE_W-1:0]     out_side
);

    sqrt_st_t             st_reg   [SQRT_STAGES];
    logic [63:0]          x_reg    [SQRT_STAGES];
    logic [SIDE_W-1:0]    side_reg [SQRT_STAGES];
    logic [SQRT_STAGES-1:0] vld_reg;

    genvar g;
    generate
        for (g = 0; g < SQRT_STAGES; g++)
        begin : g_stage
            logic              vld_prev;
            logic [SIDE_W-1:0] side_prev;
            sqrt_st_t          st_prev;
            logic [63:0]       x_prev;
            sqrt_st_t          st_next;

            if (g == 0)
            begin : g_first
                assign vld_prev  = in_vld;
                assign side_prev = in_side;
                assign st_prev   = '0;
                assign x_prev    = in_x;
            end
            else
            begin : g_next
                assign vld_prev  = vld_reg[g-1];
                assign side_prev = side_reg[g-1];
                assign st_prev   = st_reg[g-1];
                assign x_prev    = x_reg[g-1];
            end

            // digit step, top bits first
            assign st_next = sqrt_step(st_prev, x_prev[63-2*g -: 2]);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    vld_reg[g] <= 1'b0;
                else if (en)
                    vld_reg[g] <= vld_prev;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    st_reg[g]   <= st_next;
                    x_reg[g]    <= x_prev;
                    side_reg[g] <= side_prev;
                end
            end
        end
    endgenerate

    assign out_vld  = vld_reg[SQRT_STAGES-1];
    assign out_root = st_reg[SQRT_STAGES-1].root;
    assign out_side = side_reg[SQRT_STAGES-1];

endmodule

### sv/kerr_isco_radius.sv
// kerr_isco_radius: pipelined kerr isco radius from a q1.15 spin value
// depends on kic_pkg, kic_cbrt_pipe, kic_sqrt_pipe
//
//  port group        dir  handshake            payload
//  spin item         in   in_valid / in_ready   spin (s16, Q1.15)
//  radius item       out  out_valid / out_ready isco_radius_out (u20, Q4.16)
//
// the pipeline has input and square stages, 22 cube root digit stages,
// two multiply stages, 32 square root stages, one multiply stage, 32 more
// square root stages and the output register. one item per cycle unless stalled.
// a stalled output holds every stage in place; nothing is lost or repeated.
// reset clears the valid bits only.
module kerr_isco_radius
    import kic_pkg::*;
#(
    parameter int SPIN_FRAC_BITS   = 15,
    parameter int RADIUS_FRAC_BITS = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [SPIN_W-1:0] spin,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [OUT_W-1:0]         isco_radius_out
);

    localparam logic [63:0] CAP = 64'((64'd999 << SPIN_FRAC_BITS) / 64'd1000);
    localparam int MSHL = (SPIN_FRAC_BITS <= WF) ? WF - SPIN_FRAC_BITS : 0;
    localparam int MSHR = (SPIN_FRAC_BITS > WF) ? SPIN_FRAC_BITS - WF : 0;
    localparam int RSHR = (RADIUS_FRAC_BITS < WF) ? WF - RADIUS_FRAC_BITS : 0;
    localparam int RSHL = (RADIUS_FRAC_BITS >= WF) ? RADIUS_FRAC_BITS - WF : 0;
    localparam logic [63:0] HALF = (RADIUS_FRAC_BITS < WF) ? (64'd1 << (RSHR - 1)) : 64'd0;
    localparam logic [63:0] OUT_MAX = (64'd1 << OUT_W) - 64'd1;
    localparam logic [31:0] ONE_W   = 32'd1 << WF;
    localparam logic [31:0] THREE_W = 32'd3 << WF;

    logic en;

    // global advance: move when the output slot is free or being taken
    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // stage 0: magnitude, clamp, scale to q.28
    logic [16:0] mag;
    logic [63:0] mag_c;
    logic [63:0] m_wide;
    logic        s0_vld_reg;
    logic        s0_neg_reg;
    logic [27:0] s0_m_reg;

    always_comb
    begin
        mag    = spin[SPIN_W-1] ? (17'h10000 - {1'b0, spin}) : {1'b0, spin};
        mag_c  = ({47'd0, mag} > CAP) ? CAP : {47'd0, mag};
        m_wide = (SPIN_FRAC_BITS <= WF) ? (mag_c << MSHL) : (mag_c >> MSHR);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s0_vld_reg <= 1'b0;
        else if (en)
            s0_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_neg_reg <= spin[SPIN_W-1];
            s0_m_reg   <= m_wide[27:0];
        end
    end

    // stage 1: a squared
    logic [55:0] m_sq;
    logic        s1_vld_reg;
    logic        s1_neg_reg;
    logic [27:0] s1_m_reg;
    logic [27:0] s1_a2_reg;

    assign m_sq = s0_m_reg * s0_m_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (en)
            s1_vld_reg <= s0_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_neg_reg <= s0_neg_reg;
            s1_m_reg   <= s0_m_reg;
            s1_a2_reg  <= m_sq[55:28];
        end
    end

    // cube roots of 1 - a^2, 1 + a, 1 - a
    logic [CBRT_IN_W-1:0]  cb_x    [CBRT_LANES];
    logic [CBRT_OUT_W-1:0] cb_root [CBRT_LANES];
    logic                  cb_vld;
    logic [28:0]           cb_side;

    assign cb_x[0] = ONE_W[28:0] - {1'b0, s1_a2_reg};
    assign cb_x[1] = ONE_W[28:0] + {1'b0, s1_m_reg};
    assign cb_x[2] = ONE_W[28:0] - {1'b0, s1_m_reg};

    kic_cbrt_pipe #(
        .SIDE_W (29)
    ) u_cbrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s1_vld_reg),
        .in_x     (cb_x),
        .in_side  ({s1_neg_reg, s1_a2_reg}),
        .out_vld  (cb_vld),
        .out_root (cb_root),
        .out_side (cb_side)
    );

    // stage 2: z1 = 1 + cp * (cu + cv)
    logic [28:0] cp;
    logic [29:0] cuv;
    logic [58:0] z1_prod;
    logic        s2_vld_reg;
    logic        s2_neg_reg;
    logic [27:0] s2_a2_reg;
    logic [31:0] s2_z1_reg;

    always_comb
    begin
        cp      = {cb_root[0], 7'd0};
        cuv     = {1'b0, cb_root[1], 7'd0} + {1'b0, cb_root[2], 7'd0};
        z1_prod = cp * cuv;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_vld_reg <= 1'b0;
        else if (en)
            s2_vld_reg <= cb_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_neg_reg <= cb_side[28];
            s2_a2_reg  <= cb_side[27:0];
            s2_z1_reg  <= ONE_W + {1'b0, z1_prod[58:28]};
        end
    end

    // stage 3: z1 squared
    logic [63:0] z1_sq;
    logic        s3_vld_reg;
    logic        s3_neg_reg;
    logic [27:0] s3_a2_reg;
    logic [31:0] s3_z1_reg;
    logic [35:0] s3_z1sq_reg;

    assign z1_sq = s2_z1_reg * s2_z1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_vld_reg <= 1'b0;
        else if (en)
            s3_vld_reg <= s2_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_neg_reg  <= s2_neg_reg;
            s3_a2_reg   <= s2_a2_reg;
            s3_z1_reg   <= s2_z1_reg;
            s3_z1sq_reg <= z1_sq[63:28];
        end
    end

    // z2 = sqrt(3 a^2 + z1^2)
    logic [35:0] z2_arg;
    logic        sq1_vld;
    logic [31:0] z2;
    logic [32:0] sq1_side;

    assign z2_arg = {8'd0, s3_a2_reg} + {7'd0, s3_a2_reg, 1'b0} + s3_z1sq_reg;

    kic_sqrt_pipe #(
        .SIDE_W (33)
    ) u_sqrt_z2 (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s3_vld_reg),
        .in_x     ({z2_arg, 28'd0}),
        .in_side  ({s3_neg_reg, s3_z1_reg}),
        .out_vld  (sq1_vld),
        .out_root (z2),
        .out_side (sq1_side)
    );

    // stage 4: (3 - z1) * (3 + z1 + 2 z2)
    logic [29:0] t_fac;
    logic [33:0] w_fac;
    logic [63:0] tw_prod;
    logic        s4_vld_reg;
    logic        s4_neg_reg;
    logic [31:0] s4_z2_reg;
    logic [35:0] s4_tw_reg;

    always_comb
    begin
        t_fac   = (sq1_side[31:0] < THREE_W) ? 30'(THREE_W - sq1_side[31:0]) : 30'd0;
        w_fac   = {2'b00, THREE_W} + {2'b00, sq1_side[31:0]} + {1'b0, z2, 1'b0};
        tw_prod = {34'd0, t_fac} * {30'd0, w_fac};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s4_vld_reg <= 1'b0;
        else if (en)
            s4_vld_reg <= sq1_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_neg_reg <= sq1_side[32];
            s4_z2_reg  <= z2;
            s4_tw_reg  <= tw_prod[63:28];
        end
    end

    // q = sqrt of the product
    logic        sq2_vld;
    logic [31:0] q_root;
    logic [32:0] sq2_side;

    kic_sqrt_pipe #(
        .SIDE_W (33)
    ) u_sqrt_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_vld   (s4_vld_reg),
        .in_x     ({s4_tw_reg, 28'd0}),
        .in_side  ({s4_neg_reg, s4_z2_reg}),
        .out_vld  (sq2_vld),
        .out_root (q_root),
        .out_side (sq2_side)
    );

    // output stage: combine, round, saturate
    logic [33:0] r_base;
    logic [33:0] r_fin;
    logic [63:0] r_scaled;
    logic        out_vld_reg;
    logic [OUT_W-1:0] out_data_reg;

    always_comb
    begin
        r_base = {2'b00, THREE_W} + {2'b00, sq2_side[31:0]};
        if (sq2_side[32])
            r_fin = r_base + {2'b00, q_root};
        else if (r_base > {2'b00, q_root})
            r_fin = r_base - {2'b00, q_root};
        else
            r_fin = 34'd0;
        if (RADIUS_FRAC_BITS < WF)
            r_scaled = ({30'd0, r_fin} + HALF) >> RSHR;
        else
            r_scaled = {30'd0, r_fin} << RSHL;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sq2_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= (r_scaled > OUT_MAX) ? OUT_MAX[OUT_W-1:0] : r_scaled[OUT_W-1:0];
    end

    assign out_valid       = out_vld_reg;
    assign isco_radius_out = out_data_reg;

endmodule
